FILE: rtl/core/jgm_pkg.sv
// ============================================================================
// jgm_pkg - shared types and helpers for the jittered gradient map
// Holds the queue item format, the configuration bundle and the small
// arithmetic helpers used by the front and back parts.
// ============================================================================
package jgm_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int INDEX_W      = 8;
    localparam int COLOR_W      = 32;
    localparam int COEFF_W      = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] EDGE_LIMIT = 8'd24;
    localparam logic [7:0] FULL_ALPHA = 8'hFF;

    // Command codes carried in s_tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Register indexes (byte address bit 2).
    localparam logic REG_JITTER = 1'b0;
    localparam logic REG_EDGE   = 1'b1;

    // One beat as it waits between the front and back parts. For a load the
    // index is the table slot; for a pixel it is the computed lookup index.
    typedef struct packed {
        logic                 is_pixel;
        logic [INDEX_W-1:0]   index;
        logic [COLOR_W-1:0]   color;
        logic [7:0]           mask;
        logic                 last;
    } jgm_item_t;

    typedef struct packed {
        logic [COEFF_W-1:0]   coeff;
        logic                 edge_hidden;
    } jgm_cfg_t;

    // percent * 255 / 100; the divide by 100 is a reciprocal multiply by
    // 5243 / 2^19, exact for all products up to 127 * 255.
    function automatic logic [COEFF_W-1:0] jitter_coeff(input logic [6:0] percent);
        logic [14:0] scaled;
        logic [27:0] prod;
        scaled = {percent, 8'd0} - {8'd0, percent};
        prod   = {13'd0, scaled} * 28'd5243;
        return prod[27:19];
    endfunction

    // (mask * 10 * 255) >> 8 for masks below the edge limit.
    function automatic logic [7:0] fade_alpha(input logic [4:0] mask);
        logic [16:0] prod;
        prod = {12'd0, mask} * 17'd2550;
        return prod[15:8];
    endfunction

endpackage

FILE: rtl/core/jgm_front.sv
// ============================================================================
// jgm_front - input classification and lookup index
// Takes input beats whenever the queue has room, tells loads from pixels and
// works out the jittered table index for pixels.
// ============================================================================
module jgm_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  jgm_pkg::jgm_cfg_t    cfg,
    input  logic                 q_full,
    output logic                 push,
    output jgm_pkg::jgm_item_t   item
);

    logic [7:0]  entry_index;
    logic [31:0] entry_color;
    logic [7:0]  mask_alpha;
    logic [7:0]  noise_byte;
    logic [16:0] jitter_prod;
    logic [7:0]  lookup_index;

    assign entry_index = s_tdata[7:0];
    assign entry_color = s_tdata[39:8];
    assign mask_alpha  = s_tdata[47:40];
    assign noise_byte  = s_tdata[55:48];

    // 255 - mask is the bitwise inverse; the sum wraps modulo 256.
    assign jitter_prod  = {8'd0, cfg.coeff} * {9'd0, noise_byte};
    assign lookup_index = ~mask_alpha + jitter_prod[15:8];

    assign s_tready = ~q_full;
    assign push     = s_tvalid & ~q_full;

    always_comb begin
        item.is_pixel = (s_tuser == jgm_pkg::CMD_PIXEL);
        item.index    = item.is_pixel ? lookup_index : entry_index;
        item.color    = entry_color;
        item.mask     = mask_alpha;
        item.last     = s_tlast;
    end

endmodule

FILE: rtl/core/jgm_queue.sv
// ============================================================================
// jgm_queue - short queue between front and back
// A small register queue that lets the two parts stall independently.
// ============================================================================
module jgm_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  jgm_pkg::jgm_item_t   push_item,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output jgm_pkg::jgm_item_t   head_item
);

    jgm_pkg::jgm_item_t             slot_reg [jgm_pkg::QUEUE_DEPTH];
    logic [jgm_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [jgm_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [jgm_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full       = (count_reg == jgm_pkg::QCNT_W'(jgm_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/jgm_back.sv
// ============================================================================
// jgm_back - table memory, lookup and edge fade
// Writes load beats into the gradient table, reads it for pixel beats and
// applies the edge fade in front of the output register.
// ============================================================================
module jgm_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jgm_pkg::jgm_cfg_t    cfg,
    input  logic                 head_valid,
    input  jgm_pkg::jgm_item_t   head_item,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast
);

    logic [jgm_pkg::COLOR_W-1:0] color_mem [jgm_pkg::TABLE_DEPTH];

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_mask_reg;
    logic        s1_last_reg;
    logic [31:0] rd_data_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_color_reg, out_color_next;
    logic        out_last_reg;

    logic        out_free;
    logic        s1_free;
    logic        pop_pixel;
    logic        pop_load;
    logic        s1_move;
    logic        fade;

    assign out_free  = ~out_valid_reg | m_tready;
    assign s1_free   = ~s1_valid_reg | out_free;
    assign pop       = head_valid & s1_free;
    assign pop_pixel = pop & head_item.is_pixel;
    assign pop_load  = pop & ~head_item.is_pixel;
    assign s1_move   = s1_valid_reg & out_free;

    always_comb begin
        s1_valid_next  = pop_pixel | (s1_valid_reg & ~out_free);
        out_valid_next = s1_move | (out_valid_reg & ~m_tready);
        fade = cfg.edge_hidden && (s1_mask_reg < jgm_pkg::EDGE_LIMIT)
            && (rd_data_reg[31:24] == jgm_pkg::FULL_ALPHA);
        out_color_next = rd_data_reg;
        if (fade) begin
            out_color_next[31:24] = jgm_pkg::fade_alpha(s1_mask_reg[4:0]);
        end
    end

    // Table port: one write for loads, one registered read for pixels.
    always_ff @(posedge aclk) begin
        if (pop_load) begin
            color_mem[head_item.index] <= head_item.color;
        end
        if (pop_pixel) begin
            rd_data_reg <= color_mem[head_item.index];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_pixel) begin
            s1_mask_reg <= head_item.mask;
            s1_last_reg <= head_item.last;
        end
        if (s1_move) begin
            out_color_reg <= out_color_next;
            out_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/core/jittered_gradient_map_top.sv
// ============================================================================
// jittered_gradient_map_top - gradient map lookup with jitter
// Maps selection-mask pixels to colors through a 256-entry gradient table
// that is filled by load beats on the same input stream.
// ============================================================================
//
//  Channel   Direction  Handshake          Contents
//  --------  ---------  -----------------  -------------------------------------
//  s_        in         s_tvalid/s_tready  load or pixel beat, cmd in s_tuser
//  m_        out        m_tvalid/m_tready  one color per pixel beat
//  APB       in         psel/penable       jitter_percent, edge_hidden
//
// One beat is accepted per cycle while the four-entry queue has room, and a
// color passes the queue, the table read register and the output register
// before it leaves. The single table port, one access per cycle, sets the
// sustained rate of one beat per cycle while m_ does not stall. Reset clears
// the queue, the pipeline and the registers; the table holds no meaningful
// data until loaded. A stall on m_ fills the queue and then drops s_tready.
//
module jittered_gradient_map_top (
    input  logic         aclk,
    input  logic         aresetn,

    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low bit up: entry_index[7:0], entry_color[39:8],
    // mask_alpha[47:40], noise_byte[55:48]
    input  logic [55:0]  s_tdata,
    // s_tuser: cmd (0 load table entry, 1 process pixel)
    input  logic         s_tuser,
    input  logic         s_tlast,

    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low bit up: pixel_color[31:0]
    output logic [31:0]  m_tdata,
    output logic         m_tlast,

    // Register port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Configuration registers. The jitter coefficient is derived when the
    // percentage is written, so the pixel path only sees a ready operand.
    logic [6:0]                    percent_reg, percent_next;
    logic                          edge_reg, edge_next;
    logic [jgm_pkg::COEFF_W-1:0]   coeff_reg, coeff_next;
    logic                          cfg_write;
    logic                          reg_sel;

    jgm_pkg::jgm_cfg_t   cfg;
    jgm_pkg::jgm_item_t  push_item;
    jgm_pkg::jgm_item_t  head_item;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                head_valid;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel & penable & pwrite;

    always_comb begin
        percent_next = percent_reg;
        edge_next    = edge_reg;
        coeff_next   = coeff_reg;
        if (cfg_write) begin
            case (reg_sel)
                jgm_pkg::REG_JITTER: begin
                    percent_next = pwdata[6:0];
                    coeff_next   = jgm_pkg::jitter_coeff(pwdata[6:0]);
                end
                jgm_pkg::REG_EDGE: begin
                    edge_next = pwdata[0];
                end
                default: begin
                    percent_next = percent_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            percent_reg <= 7'd0;
            edge_reg    <= 1'b1;
            coeff_reg   <= '0;
        end else begin
            percent_reg <= percent_next;
            edge_reg    <= edge_next;
            coeff_reg   <= coeff_next;
        end
    end

    always_comb begin
        case (reg_sel)
            jgm_pkg::REG_JITTER: prdata = {25'd0, percent_reg};
            jgm_pkg::REG_EDGE:   prdata = {31'd0, edge_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.coeff       = coeff_reg;
    assign cfg.edge_hidden = edge_reg;

    // The front classifies beats and forms the lookup index.
    jgm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    // The queue decouples input acceptance from table access.
    jgm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The back owns the table and produces the colors in beat order.
    jgm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: tb/jittered_gradient_map_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// jittered_gradient_map_top_tb - self-checking bench for the gradient map
// Loads the gradient table through the input stream, sends pixel beats under
// several jitter and edge-fade settings, and checks every color on the
// result stream against an in-bench model of the lookup and the alpha fade.
// ============================================================================
module jittered_gradient_map_top_tb;

    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 3;
    // Queue, table read and output register: the tail wait covers a load still
    // in flight once the last color has left.
    localparam int TAIL_CYCLES    = 12;
    localparam int NUM_PHASES     = 6;
    localparam int BEATS_PER_PHASE = 210;
    localparam int TIMEOUT_NS     = 3_000_000;

    localparam int PERCENT_SCALE  = 100;
    localparam int MAX_LEVEL      = 255;
    localparam int FADE_GAIN      = 10;
    localparam int INDEX_MASK     = 8'hFF;

    // One input beat, with the fields in interface order.
    typedef struct packed {
        logic               cmd;
        logic [7:0]         index;
        logic [31:0]        color;
        logic [7:0]         mask;
        logic [7:0]         noise;
        logic               last;
    } map_beat_t;

    // A directed row: the beat, and where obvious, the color it must give.
    typedef struct packed {
        map_beat_t          beat;
        logic               typed;
        logic [31:0]        color;
    } directed_row_t;

    typedef struct {
        logic [31:0]        color;
        logic               last;
    } map_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata  = '0;
    logic         s_tuser  = jgm_pkg::CMD_LOAD;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tlast;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    jittered_gradient_map_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // The bench's own copy of the block state: the gradient table, which of
    // its slots have been loaded, and the two configuration registers.
    logic [31:0]  gradient_lut [jgm_pkg::TABLE_DEPTH];
    bit           lut_loaded   [jgm_pkg::TABLE_DEPTH];
    int           jitter_pct   = 0;
    bit           edge_fade_on = 1'b1;

    map_result_t  pending_colors [$];
    int           mismatch_count = 0;
    int           src_idle_pct   = 0;
    int           sink_idle_pct  = 0;

    int phase_percent [NUM_PHASES] = '{0, 100, 127, 53, 1, 100};
    bit phase_edge    [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    // Directed beats, run with the reset settings (no jitter, fade on), so the
    // lookup index is simply 255 - mask. The first rows load the slots that
    // the pixel rows read: an opaque color at mask zero fades to alpha zero,
    // mask 23 is the last faded value, mask 24 the first kept one, and
    // colors that are not fully opaque pass through untouched.
    directed_row_t directed_beats [17] = '{
        '{'{jgm_pkg::CMD_LOAD,  8'd255, 32'hFF112233, 8'd0,   8'h00, 1'b0}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_LOAD,  8'd0,   32'h80A0B0C0, 8'd0,   8'h00, 1'b0}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_LOAD,  8'd232, 32'hFF445566, 8'd0,   8'h00, 1'b0}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_LOAD,  8'd231, 32'hFF778899, 8'd0,   8'h00, 1'b0}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_LOAD,  8'd128, 32'h00FFFFFF, 8'd0,   8'h00, 1'b0}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_LOAD,  8'd254, 32'hFEDCBA98, 8'd0,   8'h00, 1'b0}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_LOAD,  8'd245, 32'hFF000000, 8'd0,   8'h00, 1'b0}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd0,   8'hFF, 1'b0}, 1'b1, 32'h00112233},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd255, 8'h00, 1'b1}, 1'b1, 32'h80A0B0C0},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd23,  8'h5A, 1'b0}, 1'b1, 32'hE5445566},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd24,  8'hA5, 1'b0}, 1'b1, 32'hFF778899},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd127, 8'h80, 1'b1}, 1'b1, 32'h00FFFFFF},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd1,   8'h01, 1'b0}, 1'b1, 32'hFEDCBA98},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd10,  8'h7F, 1'b0}, 1'b1, 32'h63000000},
        // A load with every ignored field at ones, then a pixel with the
        // ignored load fields at ones.
        '{'{jgm_pkg::CMD_LOAD,  8'd255, 32'hFFFFFFFF, 8'hFF,  8'hFF, 1'b1}, 1'b0, 32'h0},
        '{'{jgm_pkg::CMD_PIXEL, 8'hFF,  32'hFFFFFFFF, 8'd0,   8'h00, 1'b1}, 1'b1, 32'h00FFFFFF},
        '{'{jgm_pkg::CMD_PIXEL, 8'd0,   32'h0,        8'd24,  8'h00, 1'b1}, 1'b0, 32'h0}
    };

    // Table slot that a pixel reads under the current jitter setting.
    function automatic logic [7:0] lut_slot(input logic [7:0] mask, input logic [7:0] noise);
        int coeff;
        coeff = jitter_pct * MAX_LEVEL / PERCENT_SCALE;
        return 8'((MAX_LEVEL - int'(mask) + ((coeff * int'(noise)) >> 8)) & INDEX_MASK);
    endfunction

    // Color for one pixel beat, with the edge fade applied to opaque
    // colors under a thin mask.
    function automatic map_result_t map_pixel(input map_beat_t b);
        map_result_t r;
        int          fade;
        r.color = gradient_lut[lut_slot(b.mask, b.noise)];
        r.last  = b.last;
        if (edge_fade_on && b.mask < jgm_pkg::EDGE_LIMIT
                && r.color[31:24] == jgm_pkg::FULL_ALPHA) begin
            fade = (int'(b.mask) * FADE_GAIN * MAX_LEVEL) >> 8;
            r.color[31:24] = fade[7:0];
        end
        return r;
    endfunction

    // Applies an accepted beat to the bench state and, for a pixel, queues its color.
    task automatic record_beat(input map_beat_t b, input logic typed,
                               input logic [31:0] typed_color);
        map_result_t r;
        if (b.cmd == jgm_pkg::CMD_LOAD) begin
            gradient_lut[b.index] = b.color;
        end else begin
            r = map_pixel(b);
            if (typed) begin
                r.color = typed_color;
            end
            pending_colors.push_back(r);
        end
    endtask

    // Offers one beat, with random gaps in front of it, and waits for the
    // handshake. The generator marks loaded slots at once, since beats are
    // accepted in order.
    task automatic push_beat(input map_beat_t b, input logic typed,
                             input logic [31:0] typed_color);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        if (b.cmd == jgm_pkg::CMD_LOAD) begin
            lut_loaded[b.index] = 1'b1;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.cmd;
        s_tlast  <= b.last;
        s_tdata  <= {b.noise, b.mask, b.color, b.index};
        do @(posedge aclk); while (!s_tready);
        record_beat(b, typed, typed_color);
    endtask

    // Stops sending and waits until every color has come back, then lets a
    // trailing load finish.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_colors.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the write lands at the access edge.
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == jgm_pkg::REG_JITTER) begin
            jitter_pct = int'(value[6:0]);
        end else begin
            edge_fade_on = value[0];
        end
    endtask

    // A random load, with 40 percent of colors forced opaque so that the fade is exercised.
    function automatic map_beat_t random_load(input logic [7:0] slot);
        map_beat_t b;
        b.cmd   = jgm_pkg::CMD_LOAD;
        b.index = slot;
        b.color = $urandom();
        if ($urandom_range(99) < 40) begin
            b.color[31:24] = jgm_pkg::FULL_ALPHA;
        end
        b.mask  = 8'($urandom_range(255));
        b.noise = 8'($urandom_range(255));
        b.last  = 1'($urandom_range(1));
        return b;
    endfunction

    // The result side stalls at random; a zero rate keeps it ready.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Every color that leaves is checked against the oldest expectation.
    always @(posedge aclk) begin
        map_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got color %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = pending_colors.pop_front();
                if (m_tdata !== want.color) begin
                    $display("%0t: pixel color mismatch, expected %h, got %h",
                             $time, want.color, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: end of region mismatch, expected %b, got %b",
                             $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: directed beats under the reset settings, then random phases,
    // each with its own register setting and one of three idling patterns.
    initial begin
        map_beat_t    b;
        logic [7:0]   slot;

        foreach (lut_loaded[i]) begin
            lut_loaded[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 14;
        sink_idle_pct = 65;
        foreach (directed_beats[i]) begin
            push_beat(directed_beats[i].beat, directed_beats[i].typed,
                      directed_beats[i].color);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Registers change only with the block idle.
            drain_pipeline();
            write_register(jgm_pkg::REG_JITTER, 32'(phase_percent[ph]));
            write_register(jgm_pkg::REG_EDGE, 32'(phase_edge[ph]));
            if (ph < 2) begin
                src_idle_pct  = 14;
                sink_idle_pct = 65;
            end else if (ph < 4) begin
                src_idle_pct  = 65;
                sink_idle_pct = 14;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // Halfway through, the sender holds off until all colors
                // are back, so the block runs empty mid-stream.
                if (n == BEATS_PER_PHASE / 2) begin
                    drain_pipeline();
                end
                if ($urandom_range(99) < 25) begin
                    push_beat(random_load(8'($urandom_range(255))), 1'b0, '0);
                end else begin
                    b.cmd   = jgm_pkg::CMD_PIXEL;
                    b.index = 8'($urandom_range(255));
                    b.color = $urandom();
                    b.mask  = ($urandom_range(99) < 30)
                            ? 8'($urandom_range(jgm_pkg::EDGE_LIMIT - 8'd1))
                            : 8'($urandom_range(255));
                    b.noise = 8'($urandom_range(255));
                    b.last  = ($urandom_range(15) == 0);
                    // A slot never loaded must not be read: fill it first.
                    slot = lut_slot(b.mask, b.noise);
                    if (!lut_loaded[slot]) begin
                        push_beat(random_load(slot), 1'b0, '0);
                    end
                    push_beat(b, 1'b0, '0);
                end
            end
        end

        drain_pipeline();
        if (mismatch_count == 0 && pending_colors.size() == 0) begin
            $display("jittered_gradient_map_top verification clean");
        end else begin
            $display("jittered_gradient_map_top verification failed");
        end
        $finish;
    end

    // Backstop against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("jittered_gradient_map_top verification failed");
        $finish;
    end

endmodule
